>>> rtl/termcap_escape_decoder_macros.svh
// Assertion macros shared by the decoder modules.
`ifndef TERMCAP_ESCAPE_DECODER_MACROS_SVH
`define TERMCAP_ESCAPE_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TCD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tcd_pkg.sv
// Types and character constants for the termcap escape decoder.
`timescale 1ns / 1ps
package tcd_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CTRL_MASK = 8'h1F;

    localparam logic [7:0] CODE_ESC = 8'h1B;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_TAB = 8'h09;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_FF  = 8'h0C;

    localparam logic [0:0] CFG_DELIMITER = 1'b0;
    localparam logic [0:0] CFG_CAPACITY  = 1'b1;

    // One queue entry: the results caused by one source byte, one or two.
    typedef struct packed {
        logic       two;
        logic [7:0] data0;
        logic       last0;
        logic [7:0] data1;
        logic       last1;
    } t_cmd;

    function automatic logic [7:0] hex_value(input logic [7:0] b);
        logic [7:0] v;
        if (b <= CH_NINE) begin
            v = b - CH_ZERO;
        end else if (b >= CH_LO_A && b <= CH_LO_Z) begin
            v = b - CH_LO_A + 8'd10;
        end else begin
            v = b - CH_UP_A + 8'd10;
        end
        return v;
    endfunction

endpackage

>>> rtl/tcd_front.sv
// Front end: accepts source bytes, tracks escape phase, builds result requests.
`timescale 1ns / 1ps
module tcd_front import tcd_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_source_byte,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam logic [2:0] PH_FRESH = 3'd0;
    localparam logic [2:0] PH_TOKEN = 3'd1;
    localparam logic [2:0] PH_CARET = 3'd2;
    localparam logic [2:0] PH_ESC   = 3'd3;
    localparam logic [2:0] PH_OCT   = 3'd4;
    localparam logic [2:0] PH_HEX1  = 3'd5;
    localparam logic [2:0] PH_HEX2  = 3'd6;
    localparam logic [2:0] PH_SKIP  = 3'd7;

    logic [7:0]            r_delim;
    logic [15:0]           r_cap;
    logic [2:0]            r_phase, n_phase;
    logic [7:0]            r_acc, n_acc;
    logic [COUNT_BITS-1:0] r_rem, n_rem;

    logic [15:0]           cap_m1;
    logic [COUNT_BITS-1:0] init_rem;
    logic [COUNT_BITS-1:0] rem_base;
    logic [7:0]            b;
    logic                  is_end;
    logic                  accept;
    logic                  emit;
    t_cmd                  cmd;

    logic                  ts_emit;
    logic [7:0]            ts_data;
    logic                  ts_last;
    logic [2:0]            ts_phase;
    logic [COUNT_BITS-1:0] ts_rem;

    assign b       = i_source_byte;
    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept && emit;
    assign o_cmd   = cmd;

    // Slot count for a new string: capacity minus one, saturated to the counter.
    assign cap_m1 = (r_cap == 16'd0) ? 16'd0 : r_cap - 16'd1;
    generate
        if (COUNT_BITS >= 16) begin : g_wide
            assign init_rem = COUNT_BITS'(cap_m1);
        end else begin : g_narrow
            assign init_rem = (|cap_m1[15:COUNT_BITS]) ? '1 : cap_m1[COUNT_BITS-1:0];
        end
    endgenerate

    // Token-start decision, shared by fresh, token and octal-end handling.
    always_comb begin
        rem_base = (r_phase == PH_FRESH) ? init_rem : r_rem;
        is_end   = (b == CH_NUL) || (b == r_delim);
        ts_emit  = 1'b0;
        ts_data  = b;
        ts_last  = 1'b0;
        ts_phase = PH_TOKEN;
        ts_rem   = rem_base;
        if (is_end) begin
            ts_emit  = 1'b1;
            ts_data  = CH_NUL;
            ts_last  = 1'b1;
            ts_phase = PH_FRESH;
        end else if (rem_base == '0) begin
            ts_emit  = 1'b1;
            ts_data  = CH_NUL;
            ts_last  = 1'b1;
            ts_phase = PH_SKIP;
        end else begin
            ts_rem = rem_base - 1'b1;
            if (b == CH_CARET) begin
                ts_phase = PH_CARET;
            end else if (b == CH_BSLASH) begin
                ts_phase = PH_ESC;
            end else begin
                ts_emit = 1'b1;
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_rem   = r_rem;
        n_acc   = r_acc;
        emit    = 1'b0;
        cmd     = '0;
        case (r_phase)
            PH_FRESH, PH_TOKEN: begin
                n_phase   = ts_phase;
                n_rem     = ts_rem;
                emit      = ts_emit;
                cmd.data0 = ts_data;
                cmd.last0 = ts_last;
            end
            PH_CARET: begin
                emit = 1'b1;
                if (b == CH_NUL) begin
                    cmd.last0 = 1'b1;
                    n_phase   = PH_FRESH;
                end else begin
                    cmd.data0 = b & CTRL_MASK;
                    n_phase   = PH_TOKEN;
                end
            end
            PH_ESC: begin
                n_phase = PH_TOKEN;
                emit    = 1'b1;
                case (b)
                    CH_UP_E: cmd.data0 = CODE_ESC;
                    CH_LO_R: cmd.data0 = CODE_CR;
                    CH_LO_N: cmd.data0 = CODE_LF;
                    CH_LO_T: cmd.data0 = CODE_TAB;
                    CH_LO_B: cmd.data0 = CODE_BS;
                    CH_LO_F: cmd.data0 = CODE_FF;
                    CH_LO_X: begin
                        emit    = 1'b0;
                        n_phase = PH_HEX1;
                    end
                    CH_NUL: begin
                        cmd.last0 = 1'b1;
                        n_phase   = PH_FRESH;
                    end
                    default: begin
                        if (b inside {[CH_ZERO:CH_THREE]}) begin
                            emit    = 1'b0;
                            n_acc   = {6'd0, b[1:0]};
                            n_phase = PH_OCT;
                        end else begin
                            cmd.data0 = b;
                        end
                    end
                endcase
            end
            PH_OCT: begin
                if (b inside {[CH_ZERO:CH_SEVEN]}) begin
                    n_acc = {r_acc[4:0], b[2:0]};
                end else begin
                    // Flush the octal value, then treat this byte as a token start.
                    emit      = 1'b1;
                    cmd.data0 = r_acc;
                    cmd.two   = ts_emit;
                    cmd.data1 = ts_data;
                    cmd.last1 = ts_last;
                    n_phase   = ts_phase;
                    n_rem     = ts_rem;
                end
            end
            PH_HEX1: begin
                if (b == CH_NUL) begin
                    emit      = 1'b1;
                    cmd.last0 = 1'b1;
                    n_phase   = PH_FRESH;
                end else begin
                    n_acc   = hex_value(b);
                    n_phase = PH_HEX2;
                end
            end
            PH_HEX2: begin
                emit = 1'b1;
                if (b == CH_NUL) begin
                    cmd.last0 = 1'b1;
                    n_phase   = PH_FRESH;
                end else begin
                    cmd.data0 = {r_acc[3:0], 4'd0} + hex_value(b);
                    n_phase   = PH_TOKEN;
                end
            end
            default: begin
                // Drop bytes until the string ends.
                if (is_end) begin
                    n_phase = PH_FRESH;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= 8'd0;
            r_cap   <= 16'd256;
            r_phase <= PH_FRESH;
            r_acc   <= 8'd0;
            r_rem   <= '0;
        end else begin
            if (i_cfg_wr_en && i_cfg_index[1] == 1'b0) begin
                if (i_cfg_index[0] == CFG_DELIMITER) begin
                    r_delim <= i_cfg_data[7:0];
                end else begin
                    r_cap <= i_cfg_data;
                end
            end
            if (accept) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_rem   <= n_rem;
            end
        end
    end

endmodule

>>> rtl/tcd_fifo.sv
// Short request queue between the front and back ends.
`timescale 1ns / 1ps
`include "termcap_escape_decoder_macros.svh"
module tcd_fifo import tcd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty,
    output logic o_full
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `TCD_ASSERT_NOW(a_no_push_full, i_push, !o_full, "request pushed into full queue")
    `TCD_ASSERT_NOW(a_no_pop_empty, i_pop, !o_empty, "request popped from empty queue")

endmodule

>>> rtl/tcd_back.sv
// Back end: unpacks queued requests into result bytes behind an output register.
`timescale 1ns / 1ps
`include "termcap_escape_decoder_macros.svh"
module tcd_back import tcd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    logic       r_valid;
    logic       r_half;
    logic [7:0] r_data;
    logic       r_last;
    logic       load;

    assign load       = !r_valid || !i_stall;
    // Retire the entry once its final result has moved into the output register.
    assign o_pop      = load && !i_empty && (r_half || !i_head.two);
    assign o_valid    = r_valid;
    assign o_out_byte = r_data;
    assign o_last     = r_last;

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_data <= r_half ? i_head.data1 : i_head.data0;
            r_last <= r_half ? i_head.last1 : i_head.last0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_half <= !r_half && i_head.two;
            end
        end
    end

    `TCD_ASSERT_NOW(a_half_has_entry, r_half, !i_empty && i_head.two,
        "second result pending without a two-result request")
    `TCD_ASSERT_NEXT(a_half_after_first, load && !i_empty && !r_half && i_head.two,
        r_half, "second result of request not scheduled")

endmodule

>>> rtl/termcap_escape_decoder.sv
// Top level of the termcap escape decoder.
// Accepts one source byte per clock cycle unless stalled and decodes caret, backslash,
// octal and hex escapes into result bytes, ending each string with a 0 byte marked last.
// The front end classifies a byte in the cycle it is accepted; its results go through a
// four-request queue to the back end, whose output register presents one result byte
// per cycle unless the receiver stalls. A byte that ends an octal escape and also starts
// a token yields two results in turn; every other byte yields at most one. Input stall
// rises only when the queue is full. An accepted byte's results pass through the queue,
// then the output register. The remaining-slot counter width is set by COUNT_BITS.
`timescale 1ns / 1ps
module termcap_escape_decoder import tcd_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_source_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic push;
    logic pop;
    logic empty;
    logic full;
    t_cmd cmd;
    t_cmd head;

    tcd_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_source_byte(i_source_byte),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_full       (full),
        .o_push       (push),
        .o_cmd        (cmd)
    );

    tcd_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (cmd),
        .i_pop  (pop),
        .o_head (head),
        .o_empty(empty),
        .o_full (full)
    );

    tcd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .i_empty   (empty),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_out_byte(o_out_byte),
        .o_last    (o_last)
    );

endmodule

>>> sim/escape_decode_checker.sv
// Checker for the termcap escape decoder: predicts decoded bytes and compares them.
`timescale 1ns / 1ps
module escape_decode_checker import tcd_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_byte,
    input  logic        i_out_last,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_decoded_count,
    output int          o_result_count
);

    localparam int REPORT_LIMIT = 20;

    typedef enum logic [2:0] {
        STR_START,
        IN_TOKEN,
        AFTER_CARET,
        AFTER_BSLASH,
        IN_OCTAL,
        HEX_HIGH,
        HEX_LOW,
        DRAIN
    } t_decode_phase;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_decoded;

    t_decoded              expected_decoded[$];
    t_decode_phase         phase;
    logic [7:0]            accum;
    logic [7:0]            delimiter;
    logic [15:0]           capacity;
    logic [COUNT_BITS-1:0] slots_left;

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_decoded_count = 0;
        o_result_count  = 0;
    end

    // Slots for a new string: capacity minus one, zero counts as one, clipped to the counter.
    function automatic logic [COUNT_BITS-1:0] fresh_slots();
        longint unsigned want;
        longint unsigned ceiling;
        want    = (capacity == 16'd0) ? 0 : capacity - 1;
        ceiling = (64'd1 << COUNT_BITS) - 1;
        return COUNT_BITS'((want > ceiling) ? ceiling : want);
    endfunction

    function automatic logic [7:0] hex_digit(input logic [7:0] c);
        if (c <= CH_NINE) return c - CH_ZERO;
        if (c >= CH_LO_A && c <= CH_LO_Z) return c - CH_LO_A + 8'd10;
        return c - CH_UP_A + 8'd10;
    endfunction

    task automatic push_decoded(input logic [7:0] value, input logic last);
        t_decoded d;
        d.value = value;
        d.last  = last;
        expected_decoded.push_back(d);
    endtask

    task automatic start_token(input logic [7:0] b);
        if (b == CH_NUL || b == delimiter) begin
            push_decoded(CH_NUL, 1'b1);
            phase = STR_START;
        end else if (slots_left == '0) begin
            // out of room: terminate now, drop the rest of this string
            push_decoded(CH_NUL, 1'b1);
            phase = DRAIN;
        end else begin
            slots_left = slots_left - 1'b1;
            if (b == CH_CARET) begin
                phase = AFTER_CARET;
            end else if (b == CH_BSLASH) begin
                phase = AFTER_BSLASH;
            end else begin
                push_decoded(b, 1'b0);
                phase = IN_TOKEN;
            end
        end
    endtask

    task automatic decode_source_byte(input logic [7:0] b);
        case (phase)
            STR_START: begin
                slots_left = fresh_slots();
                start_token(b);
            end
            IN_TOKEN: start_token(b);
            AFTER_CARET: begin
                if (b == CH_NUL) begin
                    push_decoded(CH_NUL, 1'b1);
                    phase = STR_START;
                end else begin
                    push_decoded(b & CTRL_MASK, 1'b0);
                    phase = IN_TOKEN;
                end
            end
            AFTER_BSLASH: begin
                phase = IN_TOKEN;
                if (b == CH_UP_E) push_decoded(CODE_ESC, 1'b0);
                else if (b == CH_LO_R) push_decoded(CODE_CR, 1'b0);
                else if (b == CH_LO_N) push_decoded(CODE_LF, 1'b0);
                else if (b == CH_LO_T) push_decoded(CODE_TAB, 1'b0);
                else if (b == CH_LO_B) push_decoded(CODE_BS, 1'b0);
                else if (b == CH_LO_F) push_decoded(CODE_FF, 1'b0);
                else if (b >= CH_ZERO && b <= CH_THREE) begin
                    accum = b - CH_ZERO;
                    phase = IN_OCTAL;
                end else if (b == CH_LO_X) begin
                    phase = HEX_HIGH;
                end else if (b == CH_NUL) begin
                    push_decoded(CH_NUL, 1'b1);
                    phase = STR_START;
                end else begin
                    push_decoded(b, 1'b0);
                end
            end
            IN_OCTAL: begin
                if (b >= CH_ZERO && b <= CH_SEVEN) begin
                    accum = (accum << 3) + (b - CH_ZERO);
                end else begin
                    // flush the value, then treat this byte as a fresh token
                    push_decoded(accum, 1'b0);
                    start_token(b);
                end
            end
            HEX_HIGH: begin
                if (b == CH_NUL) begin
                    push_decoded(CH_NUL, 1'b1);
                    phase = STR_START;
                end else begin
                    accum = hex_digit(b);
                    phase = HEX_LOW;
                end
            end
            HEX_LOW: begin
                if (b == CH_NUL) begin
                    push_decoded(CH_NUL, 1'b1);
                    phase = STR_START;
                end else begin
                    push_decoded((accum << 4) + hex_digit(b), 1'b0);
                    phase = IN_TOKEN;
                end
            end
            default: begin
                if (b == CH_NUL || b == delimiter) phase = STR_START;
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (o_fail_count < REPORT_LIMIT) begin
            $display("[%0t] result %0d: %s got 0x%02h, want 0x%02h",
                     $realtime, o_result_count, what, got, want);
        end
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_decoded want;
        if (!i_rst_n) begin
            expected_decoded.delete();
            phase      = STR_START;
            accum      = 8'h00;
            delimiter  = 8'h00;
            capacity   = 16'd256;
            slots_left = fresh_slots();
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == {1'b0, CFG_DELIMITER}) delimiter = i_cfg_data[7:0];
                else if (i_cfg_index == {1'b0, CFG_CAPACITY}) capacity = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                o_decoded_count++;
                decode_source_byte(i_in_byte);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_decoded.size() == 0) begin
                    report_mismatch("unexpected byte", i_out_byte, 8'h00);
                end else begin
                    want = expected_decoded.pop_front();
                    if (i_out_byte !== want.value) begin
                        report_mismatch("out_byte", i_out_byte, want.value);
                    end
                    if (i_out_last !== want.last) begin
                        report_mismatch("last", {7'd0, i_out_last}, {7'd0, want.last});
                    end
                end
                o_result_count++;
            end
        end
        o_pending = expected_decoded.size();
    end

endmodule

>>> sim/tb.sv
// Testbench top for the termcap escape decoder: stimulus, register settings and verdict.
`timescale 1ns / 1ps
module tb;
    import tcd_pkg::*;

    localparam int         RANDOM_TARGET  = 1450;
    localparam int         PHASE_ITEMS    = 145;
    localparam int         MAX_WAIT       = 17;
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         DRAIN_CYCLES   = 8;
    localparam logic [1:0] REG_DELIMITER  = {1'b0, CFG_DELIMITER};
    localparam logic [1:0] REG_CAPACITY   = {1'b0, CFG_CAPACITY};
    localparam logic [1:0] REG_SPARE_LO   = 2'd2;
    localparam logic [1:0] REG_SPARE_HI   = 2'd3;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic [7:0]  i_source_byte = 8'h00;
    logic        i_stall       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [1:0]  i_cfg_index   = 2'd0;
    logic [15:0] i_cfg_data    = 16'd0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_out_byte;
    logic        o_last;

    int          fail_count;
    int          pending_count;
    int          decoded_count;
    int          result_count;
    int          stuck_cycles  = 0;
    int          setting_count = 0;
    logic        eager         = 1'b0;
    logic [7:0]  cur_delim     = 8'h00;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    termcap_escape_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_source_byte (i_source_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_last        (o_last),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    escape_decode_checker #(.COUNT_BITS(16)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_in_byte       (i_source_byte),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_out_byte      (o_out_byte),
        .i_out_last      (o_last),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count),
        .o_decoded_count (decoded_count),
        .o_result_count  (result_count)
    );

    function automatic int draw_wait();
        return eager ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Present one request after a random gap and hold it until accepted.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_wait();
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_source_byte <= b;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Drop valid and wait for every expected byte plus the pipeline latency.
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [7:0] plain_byte();
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(1, 255));
        return 8'($urandom_range(8'h20, 8'h7e));
    endfunction

    function automatic logic [7:0] hex_char();
        int pick;
        if ($urandom_range(0, 7) == 0) return 8'($urandom_range(1, 255));
        pick = $urandom_range(0, 21);
        if (pick < 10) return 8'(CH_ZERO + pick);
        if (pick < 16) return 8'(CH_LO_A + pick - 10);
        return 8'(CH_UP_A + pick - 16);
    endfunction

    function automatic logic [7:0] escape_letter();
        case ($urandom_range(0, 5))
            0:       return CH_UP_E;
            1:       return CH_LO_R;
            2:       return CH_LO_N;
            3:       return CH_LO_T;
            4:       return CH_LO_B;
            default: return CH_LO_F;
        endcase
    endfunction

    // One token of a termcap string; some of them end the string early on purpose.
    task automatic send_token();
        int digits;
        case ($urandom_range(0, 11))
            0, 1, 2: send_byte(plain_byte());
            3: begin
                send_byte(CH_CARET);
                case ($urandom_range(0, 9))
                    0:       send_byte(CH_NUL);
                    1:       send_byte(cur_delim);
                    default: send_byte(8'($urandom_range(1, 255)));
                endcase
            end
            4: begin
                send_byte(CH_BSLASH);
                send_byte(escape_letter());
            end
            5, 6: begin
                send_byte(CH_BSLASH);
                send_byte(8'(CH_ZERO + $urandom_range(0, 3)));
                digits = $urandom_range(0, 3);
                repeat (digits) send_byte(8'(CH_ZERO + $urandom_range(0, 7)));
            end
            7, 8: begin
                send_byte(CH_BSLASH);
                send_byte(CH_LO_X);
                send_byte(($urandom_range(0, 11) == 0) ? CH_NUL : hex_char());
                send_byte(($urandom_range(0, 11) == 0) ? CH_NUL : hex_char());
            end
            9: begin
                send_byte(CH_BSLASH);
                if ($urandom_range(0, 3) == 0) send_byte(cur_delim);
                else send_byte(8'($urandom_range(1, 255)));
            end
            10: begin
                send_byte(CH_BSLASH);
                send_byte(CH_NUL);
            end
            default: send_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic send_string(input logic terminate);
        int tokens;
        tokens = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 8);
        repeat (tokens) send_token();
        if (terminate) send_byte($urandom_range(0, 1) ? CH_NUL : cur_delim);
    endtask

    task automatic apply_setting(input logic [7:0] delim, input logic [15:0] cap);
        logic [15:0] spare_data;
        spare_data = 16'($urandom_range(0, 16'hffff));
        if ($urandom_range(0, 1)) begin
            write_reg(REG_DELIMITER, {spare_data[15:8], delim});
            write_reg(REG_CAPACITY, cap);
        end else begin
            write_reg(REG_CAPACITY, cap);
            write_reg(REG_DELIMITER, {spare_data[7:0], delim});
        end
        // writes to unused indexes must leave the block alone
        if ($urandom_range(0, 2) == 0) begin
            write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, spare_data);
        end
        cur_delim = delim;
        setting_count++;
    endtask

    // Receiver: wait a random number of cycles, then take the next result.
    initial begin
        int hold;
        @(posedge i_rst_n);
        forever begin
            hold = draw_wait();
            repeat (hold) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_wr_en) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, pending_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        logic [7:0]  opening[$];
        logic [7:0]  delim;
        logic [15:0] cap;
        int          goal;
        int          step;

        opening = '{CH_CARET, CH_UP_A,
                    CH_BSLASH, CH_UP_E,
                    CH_BSLASH, CH_THREE, CH_SEVEN, CH_SEVEN,
                    CH_BSLASH, CH_ZERO + 8'd2, 8'h5a,
                    CH_CARET, CH_NUL,
                    CH_BSLASH, CH_LO_X, CH_LO_F, CH_UP_A + 8'd5,
                    CH_BSLASH, CH_LO_X, CH_NUL,
                    CH_BSLASH, CH_NUL,
                    8'hff, CH_BSLASH, 8'h71, CH_NUL};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: NUL delimiter, 256-byte destination
        foreach (opening[k]) send_byte(opening[k]);
        settle();
        goal = decoded_count;

        step = 0;
        while (decoded_count < goal + RANDOM_TARGET) begin
            case (step)
                0:       begin delim = 8'h3a; cap = 16'd3;     end
                1:       begin delim = 8'hff; cap = 16'd65535; end
                2:       begin delim = 8'h00; cap = 16'd0;     end
                3:       begin delim = 8'h2c; cap = 16'd1;     end
                4:       begin delim = CH_CARET;  cap = 16'd8; end
                5:       begin delim = CH_BSLASH; cap = 16'd5; end
                6:       begin delim = CH_ZERO;   cap = 16'd20; end
                7:       begin delim = 8'h01; cap = 16'd2;     end
                8:       begin delim = 8'h00; cap = 16'd256;   end
                default: begin
                    delim = 8'($urandom_range(0, 255));
                    cap = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 16'hffff)
                                                          : $urandom_range(1, 16));
                end
            endcase
            apply_setting(delim, cap);
            eager = ($urandom_range(0, 3) == 0);
            while (decoded_count < goal + (step + 1) * PHASE_ITEMS) send_string(1'b1);
            // sometimes leave a string open so the new capacity waits for the next string
            if ($urandom_range(0, 1)) send_string(1'b0);
            settle();
            step++;
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Decoded %0d source bytes under %0d register settings (reset one included).",
                 decoded_count, setting_count + 1);
        $display("Checked %0d result bytes across caret, backslash, octal and hex escapes.",
                 result_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/tcd_pkg.sv
rtl/tcd_front.sv
rtl/tcd_fifo.sv
rtl/tcd_back.sv
rtl/termcap_escape_decoder.sv
sim/escape_decode_checker.sv
sim/tb.sv
